[hdl/m3i_pkg.sv]
`timescale 1ns / 1ps
// m3i_pkg: shared types, constants and index tables of the 3x3 matrix inverse core
// no dependencies

package m3i_pkg;

	localparam int NUM_ELEMS = 9;
	localparam int IDX_W     = 4;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_ELEMS - 1);

	// controller to datapath commands
	typedef struct packed {
		logic             mat_we;
		logic [IDX_W-1:0] mat_waddr;
		logic [IDX_W-1:0] mat_raddr;
		logic             load_a;
		logic             load_b_mat;
		logic             load_b_cof;
		logic             mul_start;
		logic             save_t;
		logic             save_cof;
		logic             cof_we;
		logic [IDX_W-1:0] cof_addr;
		logic             det_clr;
		logic             det_acc;
		logic             div_start;
		logic             out_load;
		logic [IDX_W-1:0] out_index;
	} m3i_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic mul_done;
		logic div_done;
		logic singular;
	} m3i_sts_t;

	// cofactor k = a[p]*a[q] - a[r]*a[s], packed {s, r, q, p}
	function automatic logic [4*IDX_W-1:0] cof_operands(input logic [IDX_W-1:0] k);
		logic [4*IDX_W-1:0] r;
		case (k)
			4'd0: r = {4'd7, 4'd5, 4'd8, 4'd4};
			4'd1: r = {4'd8, 4'd1, 4'd2, 4'd7};
			4'd2: r = {4'd4, 4'd2, 4'd5, 4'd1};
			4'd3: r = {4'd8, 4'd3, 4'd5, 4'd6};
			4'd4: r = {4'd2, 4'd6, 4'd8, 4'd0};
			4'd5: r = {4'd5, 4'd0, 4'd3, 4'd2};
			4'd6: r = {4'd4, 4'd6, 4'd7, 4'd3};
			4'd7: r = {4'd7, 4'd0, 4'd6, 4'd1};
			4'd8: r = {4'd3, 4'd1, 4'd4, 4'd0};
			default: r = '0;
		endcase
		return r;
	endfunction

	// cofactors 0, 3 and 6 expand the determinant along the first column
	function automatic logic is_det_cof(input logic [IDX_W-1:0] k);
		return (k == 4'd0) || (k == 4'd3) || (k == 4'd6);
	endfunction

	// matrix element paired with a determinant cofactor
	function automatic logic [IDX_W-1:0] det_row(input logic [IDX_W-1:0] k);
		logic [IDX_W-1:0] r;
		case (k)
			4'd0: r = 4'd0;
			4'd3: r = 4'd1;
			4'd6: r = 4'd2;
			default: r = 4'd0;
		endcase
		return r;
	endfunction

endpackage

[hdl/m3i_ram.sv]
`timescale 1ns / 1ps
// m3i_ram: generic single write, single read ram with registered read data
// no dependencies

module m3i_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 9
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[hdl/m3i_mul.sv]
`timescale 1ns / 1ps
// m3i_mul: sequential signed multiplier, eight multiplier bits per cycle
// no dependencies

module m3i_mul #(
	parameter int AW = 32,
	parameter int BW = 65
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [AW-1:0]     a,
	input  logic signed [BW-1:0]     b,
	output logic                     done,
	output logic signed [AW+BW-1:0]  product
);

	localparam int N    = (BW + 7) / 8;
	localparam int NB   = 8 * N;
	localparam int ACW  = AW + NB;
	localparam int PW   = AW + BW;
	localparam int CNTW = $clog2(N + 1);

	logic            busy_q;
	logic [CNTW-1:0] cnt_q;
	logic            neg_q;
	logic [AW-1:0]   a_mag_q;
	logic [NB-1:0]   b_q;
	logic [ACW-1:0]  acc_q;
	logic            done_q;
	logic [PW-1:0]   prod_q;

	logic [AW-1:0]   a_neg;
	logic [BW-1:0]   b_neg;
	logic [AW+7:0]   part;
	logic [ACW-1:0]  acc_next;
	logic [PW-1:0]   mag;
	logic [PW-1:0]   mag_neg;

	// magnitudes and one digit step, most significant digit first
	always_comb begin
		a_neg    = -a;
		b_neg    = -b;
		part     = a_mag_q * b_q[NB-1 -: 8];
		acc_next = (acc_q << 8) + ACW'(part);
		mag      = acc_next[PW-1:0];
		mag_neg  = -mag;
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(N);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// operands and accumulator
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q   <= a[AW-1] ^ b[BW-1];
			a_mag_q <= a[AW-1] ? a_neg : a;
			b_q     <= NB'(b[BW-1] ? b_neg : b);
			acc_q   <= '0;
		end else if (busy_q) begin
			acc_q <= acc_next;
			b_q   <= b_q << 8;
			if (cnt_q == CNTW'(1)) begin
				prod_q <= neg_q ? mag_neg : mag;
			end
		end
	end

	assign done    = done_q;
	assign product = prod_q;

endmodule

[hdl/m3i_div.sv]
`timescale 1ns / 1ps
// m3i_div: restoring unsigned divider, one quotient bit per cycle
// no dependencies

module m3i_div #(
	parameter int NW = 96,
	parameter int DM = 97
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DM-1:0] den,
	output logic          done,
	output logic [NW-1:0] quot
);

	localparam int CNTW = $clog2(NW + 1);

	logic            busy_q;
	logic [CNTW-1:0] cnt_q;
	logic            done_q;
	logic [NW-1:0]   work_q;
	logic [DM-1:0]   rem_q;
	logic [DM-1:0]   den_q;

	logic [DM:0]     sh;
	logic [DM:0]     diff;
	logic            fits;

	// trial subtract
	always_comb begin
		sh   = {rem_q, work_q[NW-1]};
		diff = sh - {1'b0, den_q};
		fits = (sh >= {1'b0, den_q});
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= num;
			rem_q  <= '0;
			den_q  <= den;
		end else if (busy_q) begin
			rem_q  <= fits ? diff[DM-1:0] : sh[DM-1:0];
			work_q <= {work_q[NW-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = work_q;

endmodule

[hdl/m3i_datapath.sv]
`timescale 1ns / 1ps
// m3i_datapath: element and cofactor stores, shared multiplier, divider, output register
// depends on m3i_pkg, m3i_ram, m3i_mul, m3i_div

module m3i_datapath import m3i_pkg::*; #(
	parameter int W = 32,
	parameter int F = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  m3i_cmd_t         cmd,
	output m3i_sts_t         sts,
	input  logic [W-1:0]     element_in,
	output logic [W-1:0]     element_out,
	output logic [IDX_W-1:0] element_index,
	output logic             last_element,
	output logic             singular,
	output logic [W-1:0]     determinant_out
);

	localparam int CW  = 2 * W + 1;
	localparam int PW  = W + CW;
	localparam int DTW = 3 * W + 2;
	localparam int DM  = DTW - 1;
	localparam int NW  = 2 * W + 2 * F;
	localparam int SW  = (NW > DM) ? NW : DM;

	logic [W-1:0]          mat_rdata;
	logic [CW-1:0]         cof_rdata;
	logic signed [W-1:0]   op_a_q;
	logic signed [CW-1:0]  op_b_q;
	logic signed [PW-1:0]  prod;
	logic signed [PW-1:0]  t_q;
	logic signed [CW-1:0]  cof_q;
	logic signed [DTW-1:0] det_q;
	logic                  cof_neg_q;
	logic [NW-1:0]         quot;
	logic                  mul_done;
	logic                  div_done;

	logic [PW-1:0]         cof_diff;
	logic [DTW-1:0]        det_neg;
	logic [DM-1:0]         det_mag;
	logic [CW-1:0]         cof_neg;
	logic [CW-1:0]         cof_mag;
	logic [NW-1:0]         num;
	logic                  det_zero;
	logic [W-1:0]          elem_sat;
	logic [W-1:0]          det_sat;

	logic [W-1:0]          out_elem_q;
	logic [IDX_W-1:0]      out_idx_q;
	logic                  out_last_q;
	logic                  out_sing_q;
	logic [W-1:0]          out_det_q;

	// signed magnitude to saturated two's complement
	function automatic logic [W-1:0] sat(input logic [SW-1:0] mag, input logic neg);
		logic [SW-1:0] lim;
		logic [SW-1:0] v;
		logic [SW-1:0] nv;
		lim = (SW'(1) << (W - 1)) - (neg ? SW'(0) : SW'(1));
		v   = (mag > lim) ? lim : mag;
		nv  = -v;
		return neg ? nv[W-1:0] : v[W-1:0];
	endfunction

	// matrix elements
	m3i_ram #(.WIDTH(W), .DEPTH(NUM_ELEMS)) u_mat_ram (
		.clk   (clk),
		.we    (cmd.mat_we),
		.waddr (cmd.mat_waddr),
		.wdata (element_in),
		.raddr (cmd.mat_raddr),
		.rdata (mat_rdata)
	);

	// cofactors of the adjugate
	m3i_ram #(.WIDTH(CW), .DEPTH(NUM_ELEMS)) u_cof_ram (
		.clk   (clk),
		.we    (cmd.cof_we),
		.waddr (cmd.cof_addr),
		.wdata (cof_q),
		.raddr (cmd.cof_addr),
		.rdata (cof_rdata)
	);

	m3i_mul #(.AW(W), .BW(CW)) u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.mul_start),
		.a       (op_a_q),
		.b       (op_b_q),
		.done    (mul_done),
		.product (prod)
	);

	m3i_div #(.NW(NW), .DM(DM)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (num),
		.den    (det_mag),
		.done   (div_done),
		.quot   (quot)
	);

	// magnitudes, numerator and saturated results
	always_comb begin
		cof_diff = t_q - prod;
		det_neg  = -det_q;
		det_mag  = det_q[DTW-1] ? det_neg[DM-1:0] : det_q[DM-1:0];
		cof_neg  = -cof_rdata;
		cof_mag  = cof_rdata[CW-1] ? cof_neg : cof_rdata;
		num      = {cof_mag[CW-2:0], {(2 * F){1'b0}}};
		det_zero = (det_q == '0);
		elem_sat = sat(SW'(quot), cof_neg_q ^ det_q[DTW-1]);
		det_sat  = sat(SW'(det_mag >> (2 * F)), det_q[DTW-1]);
	end

	// status to the controller
	assign sts = {mul_done, div_done, det_zero};

	// operands, partial results and determinant
	always_ff @(posedge clk) begin
		if (cmd.load_a) begin
			op_a_q <= mat_rdata;
		end
		if (cmd.load_b_mat) begin
			op_b_q <= {{(CW - W){mat_rdata[W-1]}}, mat_rdata};
		end else if (cmd.load_b_cof) begin
			op_b_q <= cof_q;
		end
		if (cmd.save_t) begin
			t_q <= prod;
		end
		if (cmd.save_cof) begin
			cof_q <= cof_diff[CW-1:0];
		end
		if (cmd.det_clr) begin
			det_q <= '0;
		end else if (cmd.det_acc) begin
			det_q <= det_q + {{(DTW - PW){prod[PW-1]}}, prod};
		end
		if (cmd.div_start) begin
			cof_neg_q <= cof_rdata[CW-1];
		end
	end

	// output item register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_elem_q <= det_zero ? '0 : elem_sat;
			out_idx_q  <= cmd.out_index;
			out_last_q <= (cmd.out_index == LAST_IDX);
			out_sing_q <= det_zero;
			out_det_q  <= det_sat;
		end
	end

	assign element_out     = out_elem_q;
	assign element_index   = out_idx_q;
	assign last_element    = out_last_q;
	assign singular        = out_sing_q;
	assign determinant_out = out_det_q;

endmodule

[hdl/m3i_ctrl.sv]
`timescale 1ns / 1ps
// m3i_ctrl: sequencer for loading, cofactor and determinant products, divisions and output
// depends on m3i_pkg

module m3i_ctrl import m3i_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  m3i_sts_t sts,
	output m3i_cmd_t cmd
);

	typedef enum logic [3:0] {
		S_LOAD, S_RDA, S_RDB, S_GETB, S_MGO, S_MWAIT,
		S_COF, S_DETA, S_DRD, S_DGO, S_DWAIT, S_OUT
	} state_t;

	typedef enum logic [1:0] {
		PH_FIRST, PH_SECOND, PH_DET
	} phase_t;

	state_t           state_q;
	phase_t           phase_q;
	logic [IDX_W-1:0] cnt_q;
	logic [IDX_W-1:0] k_q;
	logic             out_valid_q;

	logic [4*IDX_W-1:0] ops;
	logic [IDX_W-1:0]   idx_a;
	logic [IDX_W-1:0]   idx_b;

	// operand indices of the current product
	always_comb begin
		ops   = cof_operands(k_q);
		idx_a = (phase_q == PH_FIRST) ? ops[IDX_W-1:0] : ops[3*IDX_W-1 -: IDX_W];
		idx_b = (phase_q == PH_FIRST) ? ops[2*IDX_W-1 -: IDX_W] : ops[4*IDX_W-1 -: IDX_W];
	end

	// command decode
	always_comb begin
		cmd           = '0;
		cmd.mat_waddr = cnt_q;
		cmd.cof_addr  = k_q;
		cmd.out_index = k_q;
		case (state_q)
			S_LOAD: begin
				cmd.mat_we  = in_valid;
				cmd.det_clr = in_valid && (cnt_q == LAST_IDX);
			end
			S_RDA: begin
				cmd.mat_raddr = idx_a;
			end
			S_RDB: begin
				cmd.load_a    = 1'b1;
				cmd.mat_raddr = idx_b;
			end
			S_GETB: begin
				cmd.load_b_mat = 1'b1;
			end
			S_MGO: begin
				cmd.mul_start = 1'b1;
			end
			S_MWAIT: begin
				if (sts.mul_done) begin
					cmd.save_t   = (phase_q == PH_FIRST);
					cmd.save_cof = (phase_q == PH_SECOND);
					cmd.det_acc  = (phase_q == PH_DET);
				end
			end
			S_COF: begin
				cmd.cof_we    = 1'b1;
				cmd.mat_raddr = det_row(k_q);
			end
			S_DETA: begin
				cmd.load_a     = 1'b1;
				cmd.load_b_cof = 1'b1;
			end
			S_DGO: begin
				cmd.div_start = !sts.singular;
				cmd.out_load  = sts.singular;
			end
			S_DWAIT: begin
				cmd.out_load = sts.div_done;
			end
			default: begin
			end
		endcase
	end

	// state, counters and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			phase_q     <= PH_FIRST;
			cnt_q       <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_LOAD: begin
					if (in_valid) begin
						if (cnt_q == LAST_IDX) begin
							cnt_q   <= '0;
							k_q     <= '0;
							phase_q <= PH_FIRST;
							state_q <= S_RDA;
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				S_RDA:  state_q <= S_RDB;
				S_RDB:  state_q <= S_GETB;
				S_GETB: state_q <= S_MGO;
				S_MGO:  state_q <= S_MWAIT;
				S_MWAIT: begin
					if (sts.mul_done) begin
						case (phase_q)
							PH_FIRST: begin
								phase_q <= PH_SECOND;
								state_q <= S_RDA;
							end
							PH_SECOND: state_q <= S_COF;
							default: begin
								phase_q <= PH_FIRST;
								if (k_q == LAST_IDX) begin
									k_q     <= '0;
									state_q <= S_DRD;
								end else begin
									k_q     <= k_q + 1'b1;
									state_q <= S_RDA;
								end
							end
						endcase
					end
				end
				S_COF: begin
					if (is_det_cof(k_q)) begin
						phase_q <= PH_DET;
						state_q <= S_DETA;
					end else begin
						phase_q <= PH_FIRST;
						if (k_q == LAST_IDX) begin
							k_q     <= '0;
							state_q <= S_DRD;
						end else begin
							k_q     <= k_q + 1'b1;
							state_q <= S_RDA;
						end
					end
				end
				S_DETA: state_q <= S_MGO;
				S_DRD:  state_q <= S_DGO;
				S_DGO: begin
					if (sts.singular) begin
						out_valid_q <= 1'b1;
						state_q     <= S_OUT;
					end else begin
						state_q <= S_DWAIT;
					end
				end
				S_DWAIT: begin
					if (sts.div_done) begin
						out_valid_q <= 1'b1;
						state_q     <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_ready) begin
						out_valid_q <= 1'b0;
						if (k_q == LAST_IDX) begin
							k_q     <= '0;
							state_q <= S_LOAD;
						end else begin
							k_q     <= k_q + 1'b1;
							state_q <= S_DRD;
						end
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	assign in_ready  = (state_q == S_LOAD);
	assign out_valid = out_valid_q;

endmodule

[hdl/matrix3_inverse_core.sv]
`timescale 1ns / 1ps
// matrix3_inverse_core: 3x3 fixed point matrix inverse by adjugate and determinant.
// Loading accepts one element per cycle, nine elements per matrix.
// Compute: 21 products on one shared multiplier, then, for a nonsingular matrix, nine
// divisions on a one-bit-per-cycle divider with 2W+2F quotient bits, one per output item.
// No new matrix until all nine leave; asynchronous active-low reset returns to loading.

module matrix3_inverse_core import m3i_pkg::*; #(
	parameter int ELEMENT_WIDTH = 32,
	parameter int FRACTION_BITS = 16
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    s_tvalid,
	output logic                                    s_tready,
	// element_in
	input  logic [((ELEMENT_WIDTH + 7) / 8) * 8-1:0] s_tdata,
	output logic                                    m_tvalid,
	input  logic                                    m_tready,
	// element_out, element_index, determinant_out
	output logic [((2 * ELEMENT_WIDTH + 11) / 8) * 8-1:0] m_tdata,
	// last_element
	output logic                                    m_tlast,
	// singular
	output logic                                    m_tuser
);

	localparam int OUT_TDW = ((2 * ELEMENT_WIDTH + 11) / 8) * 8;

	m3i_cmd_t                 cmd;
	m3i_sts_t                 sts;
	logic [ELEMENT_WIDTH-1:0] element_out;
	logic [IDX_W-1:0]         element_index;
	logic [ELEMENT_WIDTH-1:0] determinant_out;

	m3i_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	m3i_datapath #(.W(ELEMENT_WIDTH), .F(FRACTION_BITS)) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.element_in      (s_tdata[ELEMENT_WIDTH-1:0]),
		.element_out     (element_out),
		.element_index   (element_index),
		.last_element    (m_tlast),
		.singular        (m_tuser),
		.determinant_out (determinant_out)
	);

	// pack the result item
	assign m_tdata = OUT_TDW'({determinant_out, element_index, element_out});

endmodule
